// ===== rtl/lwd_pkg.sv =====
// Shared types, constants and helpers for the D2Q5 lattice wave block.
// No dependencies; every other file but lwd_ram imports this package.
package lwd_pkg;

    localparam int DEF_GRID_COLS = 256;
    localparam int DEF_GRID_ROWS = 256;
    localparam int NUM_DIRS      = 5;
    localparam int DATA_W        = 32;
    localparam int C2_FRAC       = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_COL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ROW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SQUARED = 2'd2;

    localparam logic [7:0]  RST_SOURCE_COL    = 8'd128;
    localparam logic [7:0]  RST_SOURCE_ROW    = 8'd128;
    localparam logic [14:0] RST_SPEED_SQUARED = 15'd16384;

    localparam logic MODE_STEP = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef struct packed {
        logic               mode;
        logic signed [23:0] source_density;
        logic [7:0]         cell_col;
        logic [7:0]         cell_row;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] density;
        logic               step_done;
    } out_item_t;

    typedef struct packed {
        logic     valid;
        in_item_t item;
    } queue_head_t;

    typedef struct packed {
        logic [7:0]  source_col;
        logic [7:0]  source_row;
        logic [14:0] speed_squared;
    } cfg_t;

    typedef struct packed {
        logic clearing;
        logic sweeping;
    } eng_status_t;

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -40'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== rtl/lwd_if.sv =====
// Valid/ready channel interfaces for request and result items.
// Depends on lwd_pkg for the payload structs.
interface lwd_in_if import lwd_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface lwd_out_if import lwd_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/lattice_wave_d2q5_step.sv =====
// D2Q5 lattice-Boltzmann wave block on a periodic GRID_COLS x GRID_ROWS lattice
// of Q16.16 values. After reset a clearing pass zeroes the lattice, and no
// request is taken until it ends; configuration writes are taken at any time.
// A step request (mode 0) streams and collides every cell, one cell per cycle
// through the memory pipeline; its result carries step_done=1 and density 0.
// A read request (mode 1) first wraps each out-of-grid coordinate into the
// grid by repeated subtraction, then returns the cell's saturated density.
// Up to two requests queue while the engine works, and one finished result
// waits in the output register.
// Depends on lwd_pkg, lwd_if, lwd_ram, lwd_front and lwd_engine.
module lattice_wave_d2q5_step import lwd_pkg::*; #(
    parameter int GRID_COLS = DEF_GRID_COLS,
    parameter int GRID_ROWS = DEF_GRID_ROWS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    lwd_in_if.sink                items,
    lwd_out_if.source             results,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    cfg_t        cfg_reg, cfg_next;
    queue_head_t head;
    logic        pop;
    eng_status_t status;

    // register writes; an unknown index is dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SOURCE_COL:    cfg_next.source_col    = cfg_data[7:0];
                REG_SOURCE_ROW:    cfg_next.source_row    = cfg_data[7:0];
                REG_SPEED_SQUARED: cfg_next.speed_squared = cfg_data[14:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_col    <= RST_SOURCE_COL;
            cfg_reg.source_row    <= RST_SOURCE_ROW;
            cfg_reg.speed_squared <= RST_SPEED_SQUARED;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: accept and queue requests
    lwd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .items    (items),
        .clearing (status.clearing),
        .pop      (pop),
        .head     (head)
    );

    // back: clear, sweep and read the lattice
    lwd_engine #(.GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS)) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .pop     (pop),
        .cfg     (cfg_reg),
        .results (results),
        .status  (status)
    );

`ifndef NO_ASSERTIONS
    // a step result never carries a density
    a_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.payload.step_done |-> results.payload.density == 32'sd0)
        else $error("step result with nonzero density");

    // no result can exist before the clearing pass ends
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        status.clearing |-> !results.valid && !items.ready)
        else $error("activity during clearing pass");

    // clearing and sweeping never overlap
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(status.clearing && status.sweeping))
        else $error("clear and sweep overlap");
`endif
endmodule

// ===== rtl/lwd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lwd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/lwd_front.sv =====
// Front end: accepts requests into a two-entry queue for the engine.
// Depends on lwd_pkg and lwd_if.
module lwd_front import lwd_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    lwd_in_if.sink       items,
    input  logic         clearing,
    input  logic         pop,
    output queue_head_t  head
);
    in_item_t   ent_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;

    // hold off requests while the queue is full or the lattice is being cleared
    assign items.ready = (count_reg != 2'd2) && !clearing;
    assign push        = items.valid && items.ready;
    assign head.valid  = (count_reg != 2'd0);
    assign head.item   = ent_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg ^ push;
        rptr_next  = rptr_reg ^ pop;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wptr_reg] <= items.payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end
endmodule

// ===== rtl/lwd_engine.sv =====
// Back end: clears the lattice, runs stream+collide sweeps, serves density reads.
// Depends on lwd_pkg, lwd_if and lwd_ram.
module lwd_engine import lwd_pkg::*; #(
    parameter int GRID_COLS = DEF_GRID_COLS,
    parameter int GRID_ROWS = DEF_GRID_ROWS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  queue_head_t head,
    output logic        pop,
    input  cfg_t        cfg,
    lwd_out_if.source   results,
    output eng_status_t status
);
    localparam int CELLS = GRID_COLS * GRID_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(GRID_COLS);
    localparam int RW    = $clog2(GRID_ROWS);

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b00000001,
        ST_IDLE  = 8'b00000010,
        ST_RMOD  = 8'b00000100,
        ST_RADDR = 8'b00001000,
        ST_RREAD = 8'b00010000,
        ST_RSUM  = 8'b00100000,
        ST_SWEEP = 8'b01000000,
        ST_DRAIN = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic [AW-1:0] here_reg, here_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          bank_reg, bank_next;
    logic [7:0]    rcol_reg, rcol_next, rrow_reg, rrow_next;
    logic signed [23:0] src_reg, src_next;
    logic          out_valid_reg, out_valid_next;
    out_item_t     out_item_reg, out_item_next;

    logic                      s1_valid_reg, s1_src_reg;
    logic [AW-1:0]             s1_here_reg;
    logic                      s2_valid_reg, s3_valid_reg;
    logic [AW-1:0]             s2_here_reg, s3_here_reg;
    logic signed [DATA_W-1:0]  s2_f_reg [NUM_DIRS];
    logic signed [DATA_W-1:0]  s3_f_reg [NUM_DIRS];
    logic signed [34:0]        s2_rho_reg, s3_rho_reg;
    logic signed [32:0]        s2_jx_reg, s2_jy_reg, s3_jx_reg, s3_jy_reg;
    logic signed [50:0]        s3_p_reg;

    logic [AW-1:0]            rd_addr [NUM_DIRS];
    logic [DATA_W-1:0]        rd_data [2][NUM_DIRS];
    logic signed [DATA_W-1:0] f_cur [NUM_DIRS];
    logic [DATA_W-1:0]        wr_data [NUM_DIRS];
    logic signed [DATA_W-1:0] res [NUM_DIRS];
    logic [AW-1:0]            wr_addr;
    logic [1:0]               wr_en;
    logic [AW-1:0]            left_addr, right_addr, up_addr, down_addr;
    logic signed [34:0]       sum5, rho_in;
    logic signed [15:0]       c2_s;
    logic signed [39:0]       moving, rho40, jx40, jy40;
    logic                     src_hit, clear_wr;

    assign status.clearing = (state_reg == ST_CLEAR);
    assign status.sweeping = (state_reg == ST_SWEEP) || (state_reg == ST_DRAIN);
    assign results.valid   = out_valid_reg;
    assign results.payload = out_item_reg;

    // neighbor addresses with periodic wrap
    always_comb
    begin
        left_addr  = (col_reg == '0) ? here_reg + AW'(GRID_COLS - 1) : here_reg - AW'(1);
        right_addr = (col_reg == CW'(GRID_COLS - 1)) ? here_reg - AW'(GRID_COLS - 1)
                                                     : here_reg + AW'(1);
        up_addr    = (row_reg == '0) ? here_reg + AW'((GRID_ROWS - 1) * GRID_COLS)
                                     : here_reg - AW'(GRID_COLS);
        down_addr  = (row_reg == RW'(GRID_ROWS - 1))
                   ? here_reg - AW'((GRID_ROWS - 1) * GRID_COLS)
                   : here_reg + AW'(GRID_COLS);
        src_hit    = (32'(col_reg) == 32'(cfg.source_col)) &&
                     (32'(row_reg) == 32'(cfg.source_row));
    end

    always_comb
    begin
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            rd_addr[d] = here_reg;
        end
        if (state_reg == ST_SWEEP)
        begin
            rd_addr[1] = left_addr;
            rd_addr[2] = up_addr;
            rd_addr[3] = right_addr;
            rd_addr[4] = down_addr;
        end
    end

    // storage: one RAM per bank and direction
    for (genvar b = 0; b < 2; b++)
    begin : g_bank
        for (genvar d = 0; d < NUM_DIRS; d++)
        begin : g_dir
            lwd_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_ram (
                .clk   (clk),
                .we    (wr_en[b]),
                .waddr (wr_addr),
                .wdata (wr_data[d]),
                .raddr (rd_addr[d]),
                .rdata (rd_data[b][d])
            );
        end
    end

    // collide stage 1: gather, density and current
    always_comb
    begin
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            f_cur[d] = bank_reg ? $signed(rd_data[1][d]) : $signed(rd_data[0][d]);
        end
        sum5   = 35'(f_cur[0]) + 35'(f_cur[1]) + 35'(f_cur[2]) + 35'(f_cur[3])
               + 35'(f_cur[4]);
        rho_in = s1_src_reg ? 35'(src_reg) : sum5;
        c2_s   = $signed({1'b0, cfg.speed_squared});
    end

    // collide final stage: relax and saturate
    always_comb
    begin
        rho40  = 40'(s3_rho_reg);
        jx40   = 40'(s3_jx_reg);
        jy40   = 40'(s3_jy_reg);
        moving = 40'(s3_p_reg >>> C2_FRAC);
        res[0] = sat32(rho40 + rho40 - 40'(s3_p_reg >>> (C2_FRAC - 2)) - 40'(s3_f_reg[0]));
        res[1] = sat32(moving + jx40 - 40'(s3_f_reg[1]));
        res[2] = sat32(moving + jy40 - 40'(s3_f_reg[2]));
        res[3] = sat32(moving - jx40 - 40'(s3_f_reg[3]));
        res[4] = sat32(moving - jy40 - 40'(s3_f_reg[4]));
        clear_wr = (state_reg == ST_CLEAR);
        wr_addr  = clear_wr ? here_reg : s3_here_reg;
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            wr_data[d] = clear_wr ? '0 : res[d];
        end
        wr_en[0] = clear_wr || (s3_valid_reg && bank_reg);
        wr_en[1] = s3_valid_reg && !bank_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        here_next      = here_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        bank_next      = bank_reg;
        rcol_next      = rcol_reg;
        rrow_next      = rrow_reg;
        src_next       = src_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && !results.ready;
        pop            = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                here_next = here_reg + AW'(1);
                if (here_reg == AW'(CELLS - 1))
                begin
                    here_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (head.valid && !out_valid_reg)
                begin
                    pop       = 1'b1;
                    src_next  = head.item.source_density;
                    rcol_next = head.item.cell_col;
                    rrow_next = head.item.cell_row;
                    here_next = '0;
                    col_next  = '0;
                    row_next  = '0;
                    state_next = (head.item.mode == MODE_READ) ? ST_RMOD : ST_SWEEP;
                end
            end
            ST_RMOD:
            begin
                // reduce the read address modulo the grid, one subtract per cycle
                if (32'(rcol_reg) >= GRID_COLS)
                begin
                    rcol_next = rcol_reg - 8'(GRID_COLS);
                end
                if (32'(rrow_reg) >= GRID_ROWS)
                begin
                    rrow_next = rrow_reg - 8'(GRID_ROWS);
                end
                if ((32'(rcol_reg) < GRID_COLS) && (32'(rrow_reg) < GRID_ROWS))
                begin
                    state_next = ST_RADDR;
                end
            end
            ST_RADDR:
            begin
                here_next  = AW'(int'(rrow_reg) * GRID_COLS + int'(rcol_reg));
                state_next = ST_RREAD;
            end
            ST_RREAD:
            begin
                state_next = ST_RSUM;
            end
            ST_RSUM:
            begin
                out_item_next.density   = sat32(40'(sum5));
                out_item_next.step_done = 1'b0;
                out_valid_next          = 1'b1;
                state_next              = ST_IDLE;
            end
            ST_SWEEP:
            begin
                here_next = here_reg + AW'(1);
                if (col_reg == CW'(GRID_COLS - 1))
                begin
                    col_next = '0;
                    row_next = row_reg + RW'(1);
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
                if (here_reg == AW'(CELLS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg && !s3_valid_reg)
                begin
                    bank_next               = !bank_reg;
                    out_item_next.density   = '0;
                    out_item_next.step_done = 1'b1;
                    out_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath pipeline registers
    always_ff @(posedge clk)
    begin
        s1_here_reg <= here_reg;
        s1_src_reg  <= src_hit;
        s2_here_reg <= s1_here_reg;
        s2_rho_reg  <= rho_in;
        s2_jx_reg   <= 33'(f_cur[1]) - 33'(f_cur[3]);
        s2_jy_reg   <= 33'(f_cur[2]) - 33'(f_cur[4]);
        s3_here_reg <= s2_here_reg;
        s3_rho_reg  <= s2_rho_reg;
        s3_jx_reg   <= s2_jx_reg;
        s3_jy_reg   <= s2_jy_reg;
        s3_p_reg    <= s2_rho_reg * c2_s;
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            s2_f_reg[d] <= f_cur[d];
            s3_f_reg[d] <= s2_f_reg[d];
        end
        col_reg      <= col_next;
        row_reg      <= row_next;
        rcol_reg     <= rcol_next;
        rrow_reg     <= rrow_next;
        src_reg      <= src_next;
        out_item_reg <= out_item_next;
    end

    // the cell counter starts the clearing pass at zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            here_reg      <= '0;
            bank_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            here_reg      <= here_next;
            bank_reg      <= bank_next;
            out_valid_reg <= out_valid_next;
            s1_valid_reg  <= (state_reg == ST_SWEEP);
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
        end
    end
endmodule
